// File: sv/abf_pkg.sv
// abf_pkg: shared types, constants and the bit expansion for the block framer
// used by abf_digit_shifter, abf_sequencer and audio_bit_expanding_block_framer_unit
// no dependencies
package abf_pkg;

   localparam int unsigned SAMPLE_W  = 24;
   localparam int unsigned GROUP_W   = 64;
   localparam int unsigned DIGIT_W   = 8;
   localparam int unsigned FRAME_W   = 6 * DIGIT_W;
   localparam int unsigned DIGITS_PER_FRAME = 6;
   localparam int unsigned RES_LIMIT = 64;

   // first pad result carries 0xfd then 0xff, all later pad results are zero
   localparam logic [GROUP_W-1:0] PAD_FIRST_GROUP = 64'h0000_0000_0000_FFFD;

   localparam logic MODE_16BIT = 1'b0;
   localparam logic MODE_24BIT = 1'b1;

   typedef struct packed {
      logic active;     // a result is waiting to be produced
      logic pad;        // result comes from the pad pattern
      logic pad_first;  // first pad result of the block
      logic last;       // final result of the current item
   } ctl_type;

   // one source bit per device byte, msb first
   function automatic logic [GROUP_W-1:0] expand_byte(input logic [DIGIT_W-1:0] b);
      logic [GROUP_W-1:0] g;
      g = '0;
      for (int i = 0; i < DIGIT_W; i++) begin
         g[8*i] = b[DIGIT_W-1-i];
      end
      return g;
   endfunction

endpackage

// File: sv/abf_digit_shifter.sv
// abf_digit_shifter: frame shift register, one byte leaves per shift cycle
// depends on abf_pkg
module abf_digit_shifter (
   input  logic                          clock,
   input  logic                          load,
   input  logic                          shift,
   input  logic                          sample_mode,
   input  logic [abf_pkg::SAMPLE_W-1:0]  left_sample,
   input  logic [abf_pkg::SAMPLE_W-1:0]  right_sample,
   output logic [abf_pkg::GROUP_W-1:0]   digit_group
);
   import abf_pkg::*;

   logic [FRAME_W-1:0] shift_ff;
   logic [FRAME_W-1:0] shift_in;
   logic [3*DIGIT_W-1:0] left_bytes;
   logic [3*DIGIT_W-1:0] right_bytes;

   always_comb begin
      if (sample_mode == MODE_24BIT) begin
         left_bytes  = left_sample;
         right_bytes = right_sample;
      end else begin
         left_bytes  = {left_sample[15:0], 8'h00};
         right_bytes = {right_sample[15:0], 8'h00};
      end
   end

   // zeros shift in behind the frame, so fill frames come out as zero
   always_comb begin
      priority if (load) begin
         shift_in = {left_bytes, right_bytes};
      end else if (shift) begin
         shift_in = {shift_ff[FRAME_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      end else begin
         shift_in = shift_ff;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   assign digit_group = expand_byte(shift_ff[FRAME_W-1 -: DIGIT_W]);

endmodule

// File: sv/abf_sequencer.sv
// abf_sequencer: walks one item through data, zero fill and pad results
// holds the frames-in-block count; depends on abf_pkg
module abf_sequencer #(
   parameter int unsigned FRAMES_PER_BLOCK = 10,
   parameter int unsigned PAD_BYTES        = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              end_of_period,
   input  logic              advance,
   output abf_pkg::ctl_type  ctl
);
   import abf_pkg::*;

   localparam int unsigned PAD_GROUPS = (PAD_BYTES + 7) / 8;
   localparam int unsigned PAD_CW     = (PAD_GROUPS > 1) ? $clog2(PAD_GROUPS) : 1;
   localparam int unsigned RES_CW     = $clog2(RES_LIMIT);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DATA = 2'd1;
   localparam logic [1:0] ST_FILL = 2'd2;
   localparam logic [1:0] ST_PAD  = 2'd3;

   logic [1:0]        state_ff,  state_in;
   logic [2:0]        digit_ff,  digit_in;
   logic [3:0]        fill_ff,   fill_in;
   logic [PAD_CW-1:0] pad_ff,    pad_in;
   logic [RES_CW-1:0] res_ff,    res_in;
   logic              do_pad_ff, do_pad_in;
   logic [3:0]        frames_ff, frames_in;

   logic [3:0] frames_next;
   logic       block_full;
   logic       frame_end;
   logic       more;
   logic       last;

   assign frames_next = frames_ff + 4'd1;
   assign block_full  = frames_next >= 4'(FRAMES_PER_BLOCK);
   assign frame_end   = digit_ff == 3'(DIGITS_PER_FRAME - 1);

   always_comb begin
      unique case (state_ff)
         ST_DATA: more = !frame_end || fill_ff != 4'd0 || do_pad_ff;
         ST_FILL: more = !frame_end || fill_ff != 4'd1 || do_pad_ff;
         ST_PAD:  more = pad_ff != PAD_CW'(PAD_GROUPS - 1);
         default: more = 1'b0;
      endcase
   end

   // results past the limit are dropped, so the limit also ends the item
   assign last = !more || res_ff == RES_CW'(RES_LIMIT - 1);

   always_comb begin
      state_in  = state_ff;
      digit_in  = digit_ff;
      fill_in   = fill_ff;
      pad_in    = pad_ff;
      res_in    = res_ff;
      do_pad_in = do_pad_ff;
      frames_in = frames_ff;
      priority if (start) begin
         state_in  = ST_DATA;
         digit_in  = '0;
         pad_in    = '0;
         res_in    = '0;
         do_pad_in = end_of_period || block_full;
         fill_in   = (end_of_period && !block_full) ?
                     4'(FRAMES_PER_BLOCK) - frames_next : 4'd0;
         frames_in = (end_of_period || block_full) ? 4'd0 : frames_next;
      end else if (advance && state_ff != ST_IDLE) begin
         res_in   = res_ff + RES_CW'(1);
         digit_in = frame_end ? 3'd0 : digit_ff + 3'd1;
         if (last) begin
            state_in = ST_IDLE;
         end else begin
            unique case (state_ff)
               ST_DATA: begin
                  if (frame_end) begin
                     state_in = (fill_ff != 4'd0) ? ST_FILL : ST_PAD;
                  end
               end
               ST_FILL: begin
                  if (frame_end) begin
                     fill_in = fill_ff - 4'd1;
                     if (fill_ff == 4'd1) begin
                        state_in = ST_PAD;
                     end
                  end
               end
               ST_PAD: begin
                  pad_in = pad_ff + PAD_CW'(1);
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
      end else begin
         // idle or stalled: everything holds
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         frames_ff <= 4'd0;
      end else begin
         state_ff  <= state_in;
         frames_ff <= frames_in;
      end
      digit_ff  <= digit_in;
      fill_ff   <= fill_in;
      pad_ff    <= pad_in;
      res_ff    <= res_in;
      do_pad_ff <= do_pad_in;
   end

   assign ctl.active    = state_ff != ST_IDLE;
   assign ctl.pad       = state_ff == ST_PAD;
   assign ctl.pad_first = pad_ff == '0;
   assign ctl.last      = last;

endmodule

// File: sv/audio_bit_expanding_block_framer_unit.sv
// audio_bit_expanding_block_framer_unit: top level of the bit-expanding block framer
// instantiates abf_digit_shifter and abf_sequencer; depends on abf_pkg
//
//   port group   direction   carries
//   req_         in          one stereo frame and its end-of-period flag per item
//   rsp_         out         one 64-bit group (eight device bytes) per result, last flag
//   csr_         in          sample_mode write, no read-back
//
// one result leaves per cycle while a valid output is not stalled: a frame gives
// 6 results, plus 6 per zero-filled frame and the pad results when the block closes
// (at most 64 results); the byte shift register and the result sequencer set this
// rate; the next frame is taken in the cycle its predecessor's last result is produced
// reset clears sample_mode, the frame count, the sequencer state and the valid flag
// rsp_stall holds a valid output register and pauses the sequencer
module audio_bit_expanding_block_framer_unit #(
   parameter int unsigned FRAMES_PER_BLOCK = 10,
   parameter int unsigned PAD_BYTES        = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic                          csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [abf_pkg::SAMPLE_W-1:0]  req_left_sample,
   input  logic [abf_pkg::SAMPLE_W-1:0]  req_right_sample,
   input  logic                          req_end_of_period,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [abf_pkg::GROUP_W-1:0]   rsp_bit_group,
   output logic                          rsp_last
);
   import abf_pkg::*;

   logic               sample_mode_ff;
   logic               rsp_valid_ff,     rsp_valid_in;
   logic [GROUP_W-1:0] rsp_bit_group_ff, rsp_bit_group_in;
   logic               rsp_last_ff;

   ctl_type            ctl;
   logic               advance;
   logic               start;
   logic [GROUP_W-1:0] digit_group;

   assign advance   = ctl.active && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = ctl.active && !(advance && ctl.last);
   assign start     = req_valid && !req_stall;

   abf_sequencer #(
      .FRAMES_PER_BLOCK (FRAMES_PER_BLOCK),
      .PAD_BYTES        (PAD_BYTES)
   ) u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .end_of_period (req_end_of_period),
      .advance       (advance),
      .ctl           (ctl)
   );

   abf_digit_shifter u_shifter (
      .clock        (clock),
      .load         (start),
      .shift        (advance),
      .sample_mode  (sample_mode_ff),
      .left_sample  (req_left_sample),
      .right_sample (req_right_sample),
      .digit_group  (digit_group)
   );

   always_comb begin
      if (ctl.pad) begin
         rsp_bit_group_in = ctl.pad_first ? PAD_FIRST_GROUP : '0;
      end else begin
         rsp_bit_group_in = digit_group;
      end
   end

   always_comb begin
      priority if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_mode_ff <= MODE_16BIT;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            sample_mode_ff <= csr_write_data;
         end
      end
      if (advance) begin
         rsp_bit_group_ff <= rsp_bit_group_in;
         rsp_last_ff      <= ctl.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bit_group = rsp_bit_group_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// File: bench/framer_check_pkg.sv
// framer_check_pkg: expected-result store and frame expansion for the block framer bench
// holds the scoreboard class used by audio_bit_expanding_block_framer_unit_test
// depends on abf_pkg for widths and mode codes
package framer_check_pkg;

   import abf_pkg::*;

   class framer_scoreboard;
      int unsigned        frames_per_block;
      int unsigned        pad_bytes;
      logic               sample_mode;
      int unsigned        frames_in_block;
      int unsigned        groups_this_frame;
      int                 errors;
      logic [GROUP_W-1:0] due_groups[$];
      logic               due_last[$];

      function new(int unsigned fpb, int unsigned pb);
         frames_per_block = fpb;
         pad_bytes = pb;
         sample_mode = MODE_16BIT;
         frames_in_block = 0;
         groups_this_frame = 0;
         errors = 0;
      endfunction

      function void set_mode(logic m);
         sample_mode = m;
      endfunction

      function int pending();
         return due_groups.size();
      endfunction

      // anything past the per-item result limit is dropped by the block
      function void push_group(logic [GROUP_W-1:0] g);
         if (groups_this_frame < RES_LIMIT) begin
            due_groups.push_back(g);
            due_last.push_back(1'b0);
            groups_this_frame++;
         end
      endfunction

      // each source bit lands in bit 0 of its own byte, msb in the lowest byte
      function logic [GROUP_W-1:0] spread_bits(logic [7:0] b);
         logic [GROUP_W-1:0] g;
         g = '0;
         for (int k = 0; k < 8; k++) begin
            g = g | (GROUP_W'(b[7-k]) << (8 * k));
         end
         return g;
      endfunction

      function void push_sample(logic [SAMPLE_W-1:0] s);
         if (sample_mode == MODE_24BIT) begin
            push_group(spread_bits(s[23:16]));
            push_group(spread_bits(s[15:8]));
            push_group(spread_bits(s[7:0]));
         end else begin
            push_group(spread_bits(s[15:8]));
            push_group(spread_bits(s[7:0]));
            push_group('0);
         end
      endfunction

      function void push_padding();
         logic [GROUP_W-1:0] v;
         logic [7:0]         pb;
         int unsigned        idx;
         for (int unsigned g = 0; g < (pad_bytes + 7) / 8; g++) begin
            v = '0;
            for (int k = 0; k < 8; k++) begin
               idx = g * 8 + k;
               if (idx >= pad_bytes) pb = 8'h00;
               else if (idx == 0) pb = 8'hFD;
               else if (idx == 1) pb = 8'hFF;
               else pb = 8'h00;
               v = v | (GROUP_W'(pb) << (8 * k));
            end
            push_group(v);
         end
      endfunction

      function void expand_frame(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r, logic eop);
         groups_this_frame = 0;
         push_sample(l);
         push_sample(r);
         frames_in_block++;
         // end of period: zero frames up to a full block, then one padding
         if (eop) begin
            while (frames_in_block < frames_per_block) begin
               for (int z = 0; z < DIGITS_PER_FRAME; z++) push_group('0);
               frames_in_block++;
            end
         end
         if (frames_in_block >= frames_per_block) begin
            push_padding();
            frames_in_block = 0;
         end
         frames_in_block &= 32'hF;
         due_last[due_last.size() - 1] = 1'b1;
      endfunction

      function void check_group(logic [GROUP_W-1:0] g, logic last);
         logic [GROUP_W-1:0] want_g;
         logic               want_l;
         if (due_groups.size() == 0) begin
            $error("unexpected result: bit_group %h last %b", g, last);
            errors++;
            return;
         end
         want_g = due_groups.pop_front();
         want_l = due_last.pop_front();
         if (g !== want_g) begin
            $error("bit_group mismatch: expected %h, actual %h", want_g, g);
            errors++;
         end
         if (last !== want_l) begin
            $error("last mismatch: expected %b, actual %b", want_l, last);
            errors++;
         end
      endfunction
   endclass

endpackage

// File: bench/audio_bit_expanding_block_framer_unit_test.sv
// audio_bit_expanding_block_framer_unit_test: top of the block framer bench
// drives frames and mode writes, checks every result group through framer_scoreboard
// depends on abf_pkg, framer_check_pkg and audio_bit_expanding_block_framer_unit
module audio_bit_expanding_block_framer_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import abf_pkg::*;
   import framer_check_pkg::*;

   localparam int unsigned FRAMES_PER_BLOCK = 10;
   localparam int unsigned PAD_BYTES        = 32;
   localparam int unsigned CYCLE_LIMIT      = 1_000_000;
   localparam int unsigned RANDOM_PHASES    = 9;
   localparam int unsigned PHASE_ITEMS      = 50;
   localparam int unsigned HOLD_CYCLES      = 400;
   localparam int unsigned SETTLE_CYCLES    = 16;
   localparam int unsigned TAIL_CYCLES      = 80;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic                csr_write_data = 1'b0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_left_sample = '0;
   logic [SAMPLE_W-1:0] req_right_sample = '0;
   logic                req_end_of_period = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [GROUP_W-1:0]  rsp_bit_group;
   logic                rsp_last;

   framer_scoreboard sb;

   // sender burst state
   int  burst_left = 0;
   bit  gaps_on = 1'b0;

   // receiver state: hold requests are counted, the receiver tracks how many it served
   int  hold_asks = 0;
   int  hold_seen = 0;
   int  hold_left = 0;
   int  pattern_left = 0;
   int  stall_pct = 0;

   int unsigned cycles = 0;

   audio_bit_expanding_block_framer_unit #(
      .FRAMES_PER_BLOCK (FRAMES_PER_BLOCK),
      .PAD_BYTES        (PAD_BYTES)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_left_sample   (req_left_sample),
      .req_right_sample  (req_right_sample),
      .req_end_of_period (req_end_of_period),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_bit_group     (rsp_bit_group),
      .rsp_last          (rsp_last)
   );

   always #6 clock = ~clock;

   // receiver: long hold when asked, otherwise stretches of random stall density
   always @(posedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(20, 200);
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 20;
               2: stall_pct = 50;
               default: stall_pct = 75;
            endcase
         end
         pattern_left--;
         rsp_stall <= ($urandom_range(1, 100) <= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_group(rsp_bit_group, rsp_last);
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   task automatic send_frame(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r,
                             input logic eop);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (gaps_on) begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_left_sample <= l;
      req_right_sample <= r;
      req_end_of_period <= eop;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.expand_frame(l, r, eop);
   endtask

   task automatic send_random_frame();
      logic [SAMPLE_W-1:0] l;
      logic [SAMPLE_W-1:0] r;
      logic                eop;
      l = SAMPLE_W'($urandom());
      r = SAMPLE_W'($urandom());
      case ($urandom_range(0, 9))
         0: l = '1;
         1: r = '0;
         2: begin
            l = '0;
            r = '1;
         end
         default: ;
      endcase
      eop = ($urandom_range(0, 11) == 0);
      send_frame(l, r, eop);
   endtask

   // sender pause until every expected item has come back
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      csr_write_enable <= 1'b1;
      csr_write_data <= m;
      @(posedge clock);
      sb.set_mode(m);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic m;
      sb = new(FRAMES_PER_BLOCK, PAD_BYTES);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 16-bit: period ending on a fresh block gives the longest burst
      write_mode(MODE_16BIT);
      send_frame('1, '0, 1'b1);
      // a block filled by plain frames, the tenth also ending the period
      for (int k = 0; k < 10; k++) begin
         send_frame(24'hFFFFFF << (2 * k + 1), ~(24'hFFFFFF << (2 * k + 1)), k == 9);
      end
      drain();

      // 24-bit: end of period part way through a block
      write_mode(MODE_24BIT);
      gaps_on = 1'b1;
      send_frame('1, '0, 1'b0);
      send_frame(24'h800001, 24'h7FFFFE, 1'b0);
      send_frame(24'hAAAAAA, 24'h555555, 1'b0);
      send_frame('0, '1, 1'b1);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p < 2) m = (p == 0) ? MODE_16BIT : MODE_24BIT;
         else m = ($urandom_range(0, 1) == 0) ? MODE_16BIT : MODE_24BIT;
         write_mode(m);
         gaps_on = (p % 3) != 1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long receiver hold while the sender keeps offering items
            if (p == 4 && n == 5) hold_asks <= hold_asks + 1;
            send_random_frame();
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/abf_pkg.sv
sv/abf_digit_shifter.sv
sv/abf_sequencer.sv
sv/audio_bit_expanding_block_framer_unit.sv
bench/framer_check_pkg.sv
bench/audio_bit_expanding_block_framer_unit_test.sv
